### rtl/tvsd_pkg.sv
// ----------------------------------------------------------------------------
// tvsd_pkg
// Shared types, codes and helpers for the tagged value stream decoder.
// ----------------------------------------------------------------------------
package tvsd_pkg;

  // Default width kept from the 32-bit vector element count.
  localparam int COUNT_BITS_DEF = 32;

  // Tag bytes.
  localparam logic [7:0] TAG_TRUE   = 8'h00;
  localparam logic [7:0] TAG_FALSE  = 8'h01;
  localparam logic [7:0] TAG_SYMBOL = 8'h02;
  localparam logic [7:0] TAG_INT32  = 8'h03;
  localparam logic [7:0] TAG_DOUBLE = 8'h04;
  localparam logic [7:0] TAG_NULL   = 8'h06;
  localparam logic [7:0] TAG_VECTOR = 8'h0A;
  localparam logic [7:0] TAG_INT64  = 8'h0D;

  // Element type codes of a uniform vector.
  localparam logic [7:0] ETYPE_MAX      = 8'd11;
  localparam logic [3:0] ETYPE_CPLX_F32 = 4'd10;

  // Field byte counts.
  localparam logic [3:0] LEN_INT32  = 4'd4;
  localparam logic [3:0] LEN_INT64  = 4'd8;
  localparam logic [3:0] LEN_SYMLEN = 4'd2;
  localparam logic [3:0] LEN_VCOUNT = 4'd4;

  typedef enum logic [3:0] {
    PH_TAG, PH_INT32, PH_INT64, PH_DBL, PH_SYMLEN, PH_SYMCHR,
    PH_VTYPE, PH_VCOUNT, PH_VNPAD, PH_VPAD, PH_VELEM, PH_ERR
  } phase_t;

  typedef enum logic [3:0] {
    KIND_NULL, KIND_BOOL, KIND_INT32, KIND_INT64, KIND_DOUBLE,
    KIND_SYMLEN, KIND_SYMCHR, KIND_VCOUNT, KIND_ELEM
  } kind_t;

  typedef enum logic [1:0] {
    ERR_NONE, ERR_TAG, ERR_ETYPE
  } err_t;

  typedef struct packed {
    kind_t       kind;
    logic [3:0]  etype;
    logic [63:0] value;
    logic        imag;
    logic        last;
    err_t        err;
  } result_t;

  // Width in bytes of one element, or of one half of a complex element.
  function automatic logic [3:0] half_width(input logic [3:0] t);
    logic [3:0] w;
    case (t) inside
      4'd0, 4'd1:               w = 4'd1;
      4'd2, 4'd3:               w = 4'd2;
      4'd4, 4'd5, 4'd8, 4'd10:  w = 4'd4;
      4'd6, 4'd7, 4'd9, 4'd11:  w = 4'd8;
      default:                  w = 4'd1;
    endcase
    return w;
  endfunction

endpackage

### rtl/tvsd_parser.sv
// ----------------------------------------------------------------------------
// tvsd_parser
// Parser state and the single-pass decode of one stream byte.
// ----------------------------------------------------------------------------
module tvsd_parser
  import tvsd_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    adv_i,
  input  logic [7:0] byte_i,
  input  logic    som_i,
  output logic    emit_o,
  output result_t res_o
);

  phase_t                  phase_r, phase_nxt;
  logic [3:0]              cnt_r, cnt_nxt;
  logic [63:0]             acc_r, acc_nxt;
  logic [COUNT_BITS-1:0]   elem_r, elem_nxt;
  logic [15:0]             sym_r, sym_nxt;
  logic [7:0]              pad_r, pad_nxt;
  logic [3:0]              etype_r, etype_nxt;
  logic                    cplx_r, cplx_nxt;

  logic                    take_tag;
  logic [63:0]             acc_sh;
  logic [3:0]              cnt_dec;
  logic                    done;
  logic [15:0]             sym_dec;
  logic [7:0]              pad_dec;
  logic [COUNT_BITS-1:0]   elem_dec;
  logic                    elem_split;
  logic                    velem_last;
  logic                    hdr_last;
  logic                    bad_etype;

  // Shared decode terms.
  always_comb begin
    take_tag   = som_i || (phase_r == PH_TAG);
    acc_sh     = {acc_r[55:0], byte_i};
    cnt_dec    = (cnt_r == 4'd0) ? 4'd0 : cnt_r - 4'd1;
    done       = (cnt_dec == 4'd0);
    sym_dec    = sym_r - 16'd1;
    pad_dec    = pad_r - 8'd1;
    elem_dec   = (elem_r == '0) ? '0 : elem_r - COUNT_BITS'(1);
    // The real half of a complex element leaves the count alone.
    elem_split = (etype_r >= ETYPE_CPLX_F32) && !cplx_r;
    velem_last = !elem_split && (elem_dec == '0);
    hdr_last   = (elem_r == '0);
    bad_etype  = (byte_i > ETYPE_MAX);
  end

  // Next state.
  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    acc_nxt   = acc_r;
    elem_nxt  = elem_r;
    sym_nxt   = sym_r;
    pad_nxt   = pad_r;
    etype_nxt = etype_r;
    cplx_nxt  = cplx_r;
    if (take_tag) begin
      case (byte_i)
        TAG_NULL, TAG_TRUE, TAG_FALSE: phase_nxt = PH_TAG;
        TAG_INT32: begin
          phase_nxt = PH_INT32;
          cnt_nxt   = LEN_INT32;
          acc_nxt   = '0;
        end
        TAG_INT64: begin
          phase_nxt = PH_INT64;
          cnt_nxt   = LEN_INT64;
          acc_nxt   = '0;
        end
        TAG_DOUBLE: begin
          phase_nxt = PH_DBL;
          cnt_nxt   = LEN_INT64;
          acc_nxt   = '0;
        end
        TAG_SYMBOL: begin
          phase_nxt = PH_SYMLEN;
          cnt_nxt   = LEN_SYMLEN;
          acc_nxt   = '0;
        end
        TAG_VECTOR: phase_nxt = PH_VTYPE;
        default:    phase_nxt = PH_ERR;
      endcase
    end else begin
      case (phase_r)
        PH_INT32, PH_INT64, PH_DBL: begin
          acc_nxt = acc_sh;
          cnt_nxt = cnt_dec;
          if (done) begin
            phase_nxt = PH_TAG;
          end
        end
        PH_SYMLEN: begin
          acc_nxt = acc_sh;
          cnt_nxt = cnt_dec;
          if (done) begin
            sym_nxt   = acc_sh[15:0];
            phase_nxt = (acc_sh[15:0] != 16'd0) ? PH_SYMCHR : PH_TAG;
          end
        end
        PH_SYMCHR: begin
          sym_nxt = sym_dec;
          if (sym_dec == 16'd0) begin
            phase_nxt = PH_TAG;
          end
        end
        PH_VTYPE: begin
          if (bad_etype) begin
            phase_nxt = PH_ERR;
          end else begin
            etype_nxt = byte_i[3:0];
            phase_nxt = PH_VCOUNT;
            cnt_nxt   = LEN_VCOUNT;
            acc_nxt   = '0;
          end
        end
        PH_VCOUNT: begin
          acc_nxt = acc_sh;
          cnt_nxt = cnt_dec;
          if (done) begin
            elem_nxt  = acc_sh[COUNT_BITS-1:0];
            phase_nxt = PH_VNPAD;
          end
        end
        PH_VNPAD, PH_VPAD: begin
          pad_nxt = (phase_r == PH_VNPAD) ? byte_i : pad_dec;
          if (((phase_r == PH_VNPAD) && (byte_i == 8'd0)) ||
              ((phase_r == PH_VPAD) && (pad_dec == 8'd0))) begin
            if (hdr_last) begin
              phase_nxt = PH_TAG;
            end else begin
              cplx_nxt  = 1'b0;
              phase_nxt = PH_VELEM;
              cnt_nxt   = half_width(etype_r);
              acc_nxt   = '0;
            end
          end else begin
            phase_nxt = PH_VPAD;
          end
        end
        PH_VELEM: begin
          acc_nxt = acc_sh;
          cnt_nxt = cnt_dec;
          if (done) begin
            if (elem_split) begin
              cplx_nxt = 1'b1;
            end else begin
              cplx_nxt = 1'b0;
              elem_nxt = elem_dec;
            end
            if (velem_last) begin
              phase_nxt = PH_TAG;
            end else begin
              phase_nxt = PH_VELEM;
              cnt_nxt   = half_width(etype_r);
              acc_nxt   = '0;
            end
          end
        end
        default: phase_nxt = phase_r;
      endcase
    end
  end

  // Result of this byte.
  always_comb begin
    emit_o = 1'b0;
    res_o  = '0;
    if (take_tag) begin
      case (byte_i)
        TAG_NULL: begin
          emit_o     = 1'b1;
          res_o.kind = KIND_NULL;
          res_o.last = 1'b1;
        end
        TAG_TRUE, TAG_FALSE: begin
          emit_o      = 1'b1;
          res_o.kind  = KIND_BOOL;
          res_o.value = {63'd0, (byte_i == TAG_TRUE)};
          res_o.last  = 1'b1;
        end
        TAG_INT32, TAG_INT64, TAG_DOUBLE, TAG_SYMBOL, TAG_VECTOR: emit_o = 1'b0;
        default: begin
          emit_o     = 1'b1;
          res_o.last = 1'b1;
          res_o.err  = ERR_TAG;
        end
      endcase
    end else begin
      case (phase_r)
        PH_INT32: begin
          emit_o      = done;
          res_o.kind  = KIND_INT32;
          res_o.value = {32'd0, acc_sh[31:0]};
          res_o.last  = 1'b1;
        end
        PH_INT64, PH_DBL: begin
          emit_o      = done;
          res_o.kind  = (phase_r == PH_INT64) ? KIND_INT64 : KIND_DOUBLE;
          res_o.value = acc_sh;
          res_o.last  = 1'b1;
        end
        PH_SYMLEN: begin
          emit_o      = done;
          res_o.kind  = KIND_SYMLEN;
          res_o.value = {48'd0, acc_sh[15:0]};
          res_o.last  = (acc_sh[15:0] == 16'd0);
        end
        PH_SYMCHR: begin
          emit_o      = 1'b1;
          res_o.kind  = KIND_SYMCHR;
          res_o.value = {56'd0, byte_i};
          res_o.last  = (sym_dec == 16'd0);
        end
        PH_VTYPE: begin
          emit_o     = bad_etype;
          res_o.last = 1'b1;
          res_o.err  = ERR_ETYPE;
        end
        PH_VNPAD, PH_VPAD: begin
          emit_o = ((phase_r == PH_VNPAD) && (byte_i == 8'd0)) ||
                   ((phase_r == PH_VPAD) && (pad_dec == 8'd0));
          res_o.kind  = KIND_VCOUNT;
          res_o.etype = etype_r;
          res_o.value = 64'(elem_r);
          res_o.last  = hdr_last;
        end
        PH_VELEM: begin
          emit_o      = done;
          res_o.kind  = KIND_ELEM;
          res_o.etype = etype_r;
          res_o.value = acc_sh;
          res_o.imag  = cplx_r;
          res_o.last  = velem_last;
        end
        default: emit_o = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_TAG;
      cnt_r   <= '0;
      acc_r   <= '0;
      elem_r  <= '0;
      sym_r   <= '0;
      pad_r   <= '0;
      etype_r <= '0;
      cplx_r  <= 1'b0;
    end else if (adv_i) begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      acc_r   <= acc_nxt;
      elem_r  <= elem_nxt;
      sym_r   <= sym_nxt;
      pad_r   <= pad_nxt;
      etype_r <= etype_nxt;
      cplx_r  <= cplx_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_err_parks: assert property (@(posedge clk) disable iff (!rst_n)
    (adv_i && emit_o && (res_o.err != ERR_NONE)) |=> (phase_r == PH_ERR))
    else $error("error result did not park the parser");

  a_hdr_to_elem: assert property (@(posedge clk) disable iff (!rst_n)
    (adv_i && emit_o && (res_o.kind == KIND_VCOUNT) && !res_o.last)
      |=> ((phase_r == PH_VELEM) && !cplx_r && (cnt_r != 4'd0)))
    else $error("vector header did not start element reading");
`endif

endmodule

### rtl/tvsd_out_fifo.sv
// ----------------------------------------------------------------------------
// tvsd_out_fifo
// Two-entry result queue that decouples the parser from output stalls.
// ----------------------------------------------------------------------------
module tvsd_out_fifo
  import tvsd_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push_i,
  input  result_t res_i,
  output logic    room_o,
  output logic    valid_o,
  input  logic    ready_i,
  output result_t res_o
);

  localparam logic [1:0] FULL = 2'd2;

  result_t    mem [2];
  logic [1:0] count_r, count_nxt;
  logic       wr_ptr_r, rd_ptr_r;
  logic       pop;

  assign valid_o = (count_r != 2'd0);
  assign pop     = valid_o && ready_i;
  assign room_o  = (count_r != FULL) || ready_i;
  assign res_o   = mem[rd_ptr_r];

  always_comb begin
    count_nxt = count_r + {1'b0, push_i} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (push_i) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push_i) begin
      mem[wr_ptr_r] <= res_i;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push_i |-> ((count_r != FULL) || pop))
    else $error("result pushed into a full queue");

  a_ptr_track: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == 2'd0 || count_r == FULL) |-> (wr_ptr_r == rd_ptr_r))
    else $error("queue pointers disagree with the fill count");
`endif

endmodule

### rtl/tagged_value_stream_decoder_unit.sv
// ----------------------------------------------------------------------------
// tagged_value_stream_decoder_unit: tagged value stream decoder, top level.
// Path: input register, then parser, then the queue that drives out_tvalid.
// Throughput: one byte per cycle, single-pass parser, while queue has room.
// Reset: synchronous active-low rst_n; parser waits for a tag, queue empties.
// ----------------------------------------------------------------------------
module tagged_value_stream_decoder_unit
  import tvsd_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input byte stream.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tuser,   // [0] start_of_object
  // Decoded values.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // [63:0] value_bits
  output logic [10:0] out_tuser,  // [3:0] value_kind, [7:4] element_type,
                                  // [8] imaginary half flag, [10:9] error_code
  output logic        out_tlast   // last_of_object
);

  // The accepted byte is first held in an input register. From there the
  // parser decodes it in one combinational pass, updating its own state
  // and producing at most one result, which is written straight into the
  // two-entry output queue. The byte leaves the input register whenever
  // the queue can take a result in the same cycle, so a new request is
  // taken every cycle unless the result side has stalled with the queue
  // full.

  logic       in_valid_r;
  logic [7:0] in_byte_r;
  logic       in_som_r;
  logic       adv;
  logic       room;
  logic       emit;
  result_t    res;
  result_t    out_res;

  assign adv       = in_valid_r && room;
  assign in_tready = !in_valid_r || room;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  // The payload needs no reset; it is only looked at behind in_valid_r.
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_byte_r <= in_tdata;
      in_som_r  <= in_tuser;
    end
  end

  tvsd_parser #(
    .COUNT_BITS (COUNT_BITS)
  ) u_parser (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv_i  (adv),
    .byte_i (in_byte_r),
    .som_i  (in_som_r),
    .emit_o (emit),
    .res_o  (res)
  );

  // A result is only pushed when the parser actually consumes its byte.
  tvsd_out_fifo u_out_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (adv && emit),
    .res_i   (res),
    .room_o  (room),
    .valid_o (out_tvalid),
    .ready_i (out_tready),
    .res_o   (out_res)
  );

  assign out_tdata = out_res.value;
  assign out_tuser = {out_res.err, out_res.imag, out_res.etype, out_res.kind};
  assign out_tlast = out_res.last;

endmodule
